FILE: sv/conveyor_sort_sequencer_macros.svh
// Assertion macros shared by the conveyor sort sequencer RTL.
// Depends on signals named clock and reset in the module that uses them.
`ifndef CONVEYOR_SORT_SEQUENCER_MACROS_SVH
`define CONVEYOR_SORT_SEQUENCER_MACROS_SVH

// same-cycle implication
`define CNVS_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CNVS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/cnvs_pkg.sv
// Package for the conveyor sort sequencer: sizes, codes, beat-side structs.
// Used by cnvs_line, cnvs_queue and conveyor_sort_sequencer; depends on nothing.
package cnvs_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 3;
   localparam int MSG_W       = 3;
   localparam int COUNT_W     = 8;
   localparam int CSR_IDX_W   = 2;

   localparam logic [MODE_W-1:0] MODE_RUN        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLASSIFY   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SORT_OUT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SORT_BACK  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HOME       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RESET_WAIT = 3'd5;

   localparam logic [MSG_W-1:0] MSG_NONE       = 3'd0;
   localparam logic [MSG_W-1:0] MSG_SCANNING   = 3'd1;
   localparam logic [MSG_W-1:0] MSG_SORTING    = 3'd2;
   localparam logic [MSG_W-1:0] MSG_SPEED_SET  = 3'd3;
   localparam logic [MSG_W-1:0] MSG_SPEED_BAD  = 3'd4;
   localparam logic [MSG_W-1:0] MSG_DO_NOTHING = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_SLIDER_POWER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_SPEED = 2'd2;

   localparam logic [DATA_W-1:0] SLIDER_POWER_RST  = 16'd50000;
   localparam logic [DATA_W-1:0] SPEED_LIMIT_RST   = 16'd50000;
   localparam logic [DATA_W-1:0] DEFAULT_SPEED_RST = 16'd15000;

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_N  = 8'h6E;
   localparam logic [BYTE_W-1:0] CHAR_D  = 8'h64;
   localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;
   localparam logic [BYTE_W-1:0] WORD_LEN = 8'd5;
   localparam logic [BYTE_W-1:0] POS_MAX  = 8'hFF;

   function automatic logic [BYTE_W-1:0] speed_char(input logic [2:0] p);
      logic [BYTE_W-1:0] c;
      unique case (p)
         3'd0: c = 8'h73;
         3'd1: c = 8'h70;
         3'd2: c = 8'h65;
         3'd3: c = 8'h65;
         3'd4: c = 8'h64;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   typedef struct packed {
      logic              step;
      logic              clear;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_byte;
   } line_ctrl_type;

   typedef struct packed {
      logic              pending;
      logic              first_n;
      logic              first_d;
      logic              speed_form;
      logic              speed_digits;
      logic [DATA_W-1:0] total;
   } line_status_type;

   typedef struct packed {
      logic push;
      logic push_bit;
      logic pop;
      logic clear;
   } queue_ctrl_type;

   typedef struct packed {
      logic [Q_CNT_W-1:0] fill;
      logic               full;
      logic               empty;
      logic               head_bit;
   } queue_status_type;

endpackage

FILE: sv/cnvs_line.sv
// Command line assembler: collects UART bytes into one pending line.
// Depends on cnvs_pkg.
module cnvs_line (
   input  logic                     clock,
   input  logic                     reset,
   input  cnvs_pkg::line_ctrl_type   ctrl,
   output cnvs_pkg::line_status_type status
);
   import cnvs_pkg::*;

   logic [BYTE_W-1:0] first_ff, first_in;
   logic [BYTE_W-1:0] pos_ff, pos_in;
   logic              prefix_ff, prefix_in;
   logic [DATA_W-1:0] total_ff, total_in;
   logic              bad_ff, bad_in;
   logic              pending_ff, pending_in;
   logic [DATA_W-1:0] total_base;
   logic [DATA_W+3:0] product;
   logic [3:0]        digit;

   assign digit      = 4'(ctrl.rx_byte - CHAR_0);
   assign total_base = ctrl.clear ? '0 : total_ff;
   assign product    = ({4'd0, total_base} << 3) + ({4'd0, total_base} << 1)
                     + {16'd0, digit};

   always_comb begin
      first_in   = ctrl.clear ? '0 : first_ff;
      pos_in     = ctrl.clear ? '0 : pos_ff;
      prefix_in  = ctrl.clear ? 1'b0 : prefix_ff;
      total_in   = total_base;
      bad_in     = ctrl.clear ? 1'b0 : bad_ff;
      pending_in = ctrl.clear ? 1'b0 : pending_ff;
      if (ctrl.rx_valid && !pending_in) begin
         if (ctrl.rx_byte == CHAR_CR || ctrl.rx_byte == CHAR_LF) begin
            if (pos_in != '0) begin
               pending_in = 1'b1;
            end
         end else begin
            if (pos_in == '0) begin
               first_in = ctrl.rx_byte;
            end
            if (pos_in < WORD_LEN) begin
               prefix_in = (pos_in == '0 || prefix_in) &&
                           ctrl.rx_byte == speed_char(pos_in[2:0]);
            end else if (ctrl.rx_byte >= CHAR_0 && ctrl.rx_byte <= CHAR_9) begin
               total_in = (product[DATA_W+3:DATA_W] != '0) ? '1 : product[DATA_W-1:0];
            end else begin
               bad_in = 1'b1;
            end
            pos_in = (pos_in != POS_MAX) ? pos_in + 8'd1 : POS_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= '0;
         pos_ff     <= '0;
         prefix_ff  <= 1'b0;
         total_ff   <= '0;
         bad_ff     <= 1'b0;
         pending_ff <= 1'b0;
      end else if (ctrl.step) begin
         first_ff   <= first_in;
         pos_ff     <= pos_in;
         prefix_ff  <= prefix_in;
         total_ff   <= total_in;
         bad_ff     <= bad_in;
         pending_ff <= pending_in;
      end
   end

   assign status.pending      = pending_ff;
   assign status.first_n      = (first_ff == CHAR_N);
   assign status.first_d      = (first_ff == CHAR_D);
   assign status.speed_form   = prefix_ff && (pos_ff >= WORD_LEN);
   assign status.speed_digits = (pos_ff > WORD_LEN) && !bad_ff;
   assign status.total        = total_ff;

endmodule

FILE: sv/cnvs_queue.sv
// Decision queue: circular buffer of keep/reject bits with a prefetched head.
// Depends on cnvs_pkg.
module cnvs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  cnvs_pkg::queue_ctrl_type   ctrl,
   output cnvs_pkg::queue_status_type status
);
   import cnvs_pkg::*;

   logic               mem [QUEUE_DEPTH];
   logic [Q_IDX_W-1:0] head_ff, head_in;
   logic [Q_CNT_W-1:0] fill_ff, fill_in;
   logic               head_bit_ff;
   logic [Q_IDX_W:0]   slot_sum;
   logic [Q_IDX_W-1:0] wr_addr;

   assign slot_sum = {1'b0, head_ff} + (Q_IDX_W + 1)'(fill_ff);
   assign wr_addr  = (slot_sum >= (Q_IDX_W + 1)'(QUEUE_DEPTH))
                   ? Q_IDX_W'(slot_sum - (Q_IDX_W + 1)'(QUEUE_DEPTH))
                   : slot_sum[Q_IDX_W-1:0];

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      priority if (ctrl.clear) begin
         head_in = '0;
         fill_in = '0;
      end else if (ctrl.pop) begin
         head_in = (head_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end else if (ctrl.push) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // read the new head every cycle, forward a write to the same slot
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wr_addr] <= ctrl.push_bit;
      end
      head_bit_ff <= (ctrl.push && wr_addr == head_in) ? ctrl.push_bit : mem[head_in];
   end

   assign status.fill     = fill_ff;
   assign status.full     = (fill_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign status.empty    = (fill_ff == '0);
   assign status.head_bit = head_bit_ff;

endmodule

FILE: sv/conveyor_sort_sequencer.sv
// Conveyor sort sequencer: one sensor/UART beat in, one output beat out.
// Response beat registered, valid in the cycle after the request beat is accepted; one beat
// per cycle unless rsp_stall stalls requests, set by the single mode register and one decision queue access per beat.
// Synchronous active-high reset: run mode, empty queue, registers to defaults.
// Depends on cnvs_pkg, cnvs_line, cnvs_queue and the assertion macro header.
`include "conveyor_sort_sequencer_macros.svh"

module conveyor_sort_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [cnvs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cnvs_pkg::DATA_W-1:0]       csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_entry_clear,
   input  logic                              req_sort_clear,
   input  logic                              req_slider_at_front,
   input  logic                              req_slider_at_back,
   input  logic                              req_home_button,
   input  logic                              req_reset_button,
   input  logic                              req_rx_valid,
   input  logic [cnvs_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cnvs_pkg::DATA_W-1:0]       rsp_belt_speed,
   output logic [cnvs_pkg::DATA_W-1:0]       rsp_slider_drive,
   output logic                              rsp_slider_backward,
   output logic                              rsp_led_strip_on,
   output logic                              rsp_laser_on,
   output logic                              rsp_pusher_out,
   output logic [cnvs_pkg::COUNT_W-1:0]      rsp_queued_count,
   output logic [cnvs_pkg::MSG_W-1:0]        rsp_message
);
   import cnvs_pkg::*;

   logic [DATA_W-1:0] slider_power_ff, speed_limit_ff, default_speed_ff;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              entry_off_ff, entry_off_in;
   logic              sort_off_ff, sort_off_in;
   logic [DATA_W-1:0] belt_ff, belt_in;
   logic              accept;
   logic              line_clear;
   logic [MSG_W-1:0]  msg;
   logic [Q_CNT_W-1:0] count_next;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] belt_out_ff, belt_out_in;
   logic [DATA_W-1:0] drive_ff, drive_in;
   logic              back_ff, back_in;
   logic              led_ff, led_in;
   logic              laser_ff, laser_in;
   logic              pusher_ff, pusher_in;
   logic [COUNT_W-1:0] count_ff;
   logic [MSG_W-1:0]  msg_ff;

   line_ctrl_type    line_ctrl;
   line_status_type  line_stat;
   queue_ctrl_type   q_ctrl;
   queue_status_type q_stat;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         slider_power_ff  <= SLIDER_POWER_RST;
         speed_limit_ff   <= SPEED_LIMIT_RST;
         default_speed_ff <= DEFAULT_SPEED_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SLIDER_POWER:  slider_power_ff  <= csr_data;
            CSR_SPEED_LIMIT:   speed_limit_ff   <= csr_data;
            CSR_DEFAULT_SPEED: default_speed_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      entry_off_in = entry_off_ff;
      sort_off_in  = sort_off_ff;
      belt_in      = belt_ff;
      msg          = MSG_NONE;
      line_clear   = 1'b0;
      q_ctrl       = '0;
      unique case (mode_ff)
         MODE_RESET_WAIT: begin
            if (!req_reset_button) begin
               mode_in      = MODE_RUN;
               entry_off_in = 1'b0;
               sort_off_in  = 1'b0;
               belt_in      = default_speed_ff;
               line_clear   = 1'b1;
               q_ctrl.clear = 1'b1;
            end
         end
         MODE_CLASSIFY: begin
            if (req_reset_button) begin
               mode_in = MODE_RESET_WAIT;
            end else if (line_stat.pending) begin
               if (line_stat.first_n) begin
                  msg = MSG_DO_NOTHING;
               end else begin
                  q_ctrl.push     = !q_stat.full;
                  q_ctrl.push_bit = !line_stat.first_d;
                  msg             = MSG_SCANNING;
               end
               line_clear = 1'b1;
               mode_in    = MODE_RUN;
            end
         end
         MODE_SORT_OUT: begin
            if (req_slider_at_front) begin
               mode_in = MODE_SORT_BACK;
            end
         end
         MODE_SORT_BACK, MODE_HOME: begin
            if (req_slider_at_back) begin
               mode_in = MODE_RUN;
            end
         end
         default: begin
            mode_in = MODE_RUN;
            priority if (req_reset_button) begin
               mode_in = MODE_RESET_WAIT;
            end else if (!req_entry_clear && !entry_off_ff) begin
               entry_off_in = 1'b1;
               mode_in      = MODE_CLASSIFY;
            end else if (!req_sort_clear && !q_stat.empty && !sort_off_ff) begin
               sort_off_in = 1'b1;
               q_ctrl.pop  = 1'b1;
               msg         = MSG_SORTING;
               if (q_stat.head_bit) begin
                  mode_in = MODE_SORT_OUT;
               end
            end else if (req_home_button) begin
               mode_in = MODE_HOME;
            end else if (line_stat.pending && line_stat.speed_form) begin
               if (line_stat.speed_digits && line_stat.total <= speed_limit_ff) begin
                  belt_in = line_stat.total;
                  msg     = MSG_SPEED_SET;
               end else begin
                  msg = MSG_SPEED_BAD;
               end
               line_clear = 1'b1;
            end
            if (req_entry_clear) begin
               entry_off_in = 1'b0;
            end
            if (req_sort_clear) begin
               sort_off_in = 1'b0;
            end
         end
      endcase
      q_ctrl.push  = q_ctrl.push && accept;
      q_ctrl.pop   = q_ctrl.pop && accept;
      q_ctrl.clear = q_ctrl.clear && accept;
   end

   always_comb begin
      belt_out_in = '0;
      drive_in    = '0;
      back_in     = 1'b0;
      led_in      = 1'b0;
      laser_in    = 1'b1;
      pusher_in   = 1'b0;
      unique case (mode_in)
         MODE_CLASSIFY: begin
            led_in    = 1'b1;
            laser_in  = 1'b0;
            pusher_in = 1'b1;
         end
         MODE_SORT_OUT: begin
            drive_in = slider_power_ff;
         end
         MODE_SORT_BACK: begin
            drive_in = slider_power_ff;
            back_in  = 1'b1;
         end
         MODE_HOME: begin
            belt_out_in = belt_in;
            drive_in    = slider_power_ff;
            back_in     = 1'b1;
         end
         MODE_RESET_WAIT: ;
         default: begin
            belt_out_in = belt_in;
         end
      endcase
   end

   assign count_next = q_ctrl.clear ? '0
                     : q_stat.fill + Q_CNT_W'(q_ctrl.push) - Q_CNT_W'(q_ctrl.pop);

   assign line_ctrl.step     = accept;
   assign line_ctrl.clear    = line_clear;
   assign line_ctrl.rx_valid = req_rx_valid;
   assign line_ctrl.rx_byte  = req_rx_byte;

   cnvs_line u_line (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (line_ctrl),
      .status (line_stat)
   );

   cnvs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (q_ctrl),
      .status (q_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RUN;
         entry_off_ff <= 1'b0;
         sort_off_ff  <= 1'b0;
         belt_ff      <= DEFAULT_SPEED_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff      <= mode_in;
            entry_off_ff <= entry_off_in;
            sort_off_ff  <= sort_off_in;
            belt_ff      <= belt_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         belt_out_ff <= belt_out_in;
         drive_ff    <= drive_in;
         back_ff     <= back_in;
         led_ff      <= led_in;
         laser_ff    <= laser_in;
         pusher_ff   <= pusher_in;
         count_ff    <= COUNT_W'(count_next);
         msg_ff      <= msg;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_belt_speed      = belt_out_ff;
   assign rsp_slider_drive    = drive_ff;
   assign rsp_slider_backward = back_ff;
   assign rsp_led_strip_on    = led_ff;
   assign rsp_laser_on        = laser_ff;
   assign rsp_pusher_out      = pusher_ff;
   assign rsp_queued_count    = count_ff;
   assign rsp_message         = msg_ff;

   `CNVS_ASSERT(a_fill_bound, 1'b1, q_stat.fill <= Q_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `CNVS_ASSERT_NEXT(a_pop_fill, q_ctrl.pop, q_stat.fill == $past(q_stat.fill) - 1'b1, "pop lost")
   `CNVS_ASSERT_NEXT(a_classify_done, accept && mode_ff == MODE_CLASSIFY && !req_reset_button && line_stat.pending, mode_ff == MODE_RUN && !line_stat.pending, "classification not consumed")

endmodule

FILE: tb/conveyor_sort_sequencer_checker.sv
// Scoreboard for conveyor_sort_sequencer: mirrors the sequencer state from the
// CSR and request beats and checks every response beat in order.
// Depends on cnvs_pkg for sizes, mode, message and register codes.
module conveyor_sort_sequencer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [cnvs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cnvs_pkg::DATA_W-1:0]    csr_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_entry_clear,
   input  logic                           req_sort_clear,
   input  logic                           req_slider_at_front,
   input  logic                           req_slider_at_back,
   input  logic                           req_home_button,
   input  logic                           req_reset_button,
   input  logic                           req_rx_valid,
   input  logic [cnvs_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [cnvs_pkg::DATA_W-1:0]    rsp_belt_speed,
   input  logic [cnvs_pkg::DATA_W-1:0]    rsp_slider_drive,
   input  logic                           rsp_slider_backward,
   input  logic                           rsp_led_strip_on,
   input  logic                           rsp_laser_on,
   input  logic                           rsp_pusher_out,
   input  logic [cnvs_pkg::COUNT_W-1:0]   rsp_queued_count,
   input  logic [cnvs_pkg::MSG_W-1:0]     rsp_message,
   output int                             fails,
   output int                             due_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cnvs_pkg::*;

   localparam logic [0:4][BYTE_W-1:0] SPEED_WORD = "speed";

   typedef struct {
      logic [DATA_W-1:0]  belt;
      logic [DATA_W-1:0]  drive;
      logic               backward;
      logic               led;
      logic               laser;
      logic               pusher;
      logic [COUNT_W-1:0] queued;
      logic [MSG_W-1:0]   note;
   } panel_type;

   panel_type panel_due[$];

   logic [DATA_W-1:0] power;
   logic [DATA_W-1:0] speed_cap;
   logic [DATA_W-1:0] boot_speed;
   logic [DATA_W-1:0] belt_set;
   logic [MODE_W-1:0] mode;
   bit                entry_off;
   bit                sort_off;
   bit                reject_log [QUEUE_DEPTH];
   int                head;
   int                fill;
   logic [BYTE_W-1:0] first_char;
   int                line_len;
   int                digit_sum;
   bit                word_ok;
   bit                digit_err;
   bit                line_waiting;

   function automatic void clear_line();
      first_char   = '0;
      line_len     = 0;
      word_ok      = 0;
      digit_sum    = 0;
      digit_err    = 0;
      line_waiting = 0;
   endfunction

   function automatic void restore_state();
      mode      = MODE_RUN;
      entry_off = 0;
      sort_off  = 0;
      foreach (reject_log[i]) reject_log[i] = 0;
      head      = 0;
      fill      = 0;
      belt_set  = boot_speed;
      clear_line();
   endfunction

   function automatic void take_char(input logic [BYTE_W-1:0] ch);
      int t;
      if (line_waiting) return;
      if (ch == CHAR_CR || ch == CHAR_LF) begin
         if (line_len > 0) line_waiting = 1;
         return;
      end
      if (line_len == 0) first_char = ch;
      if (line_len < 5) begin
         word_ok = (line_len == 0 || word_ok) && ch == SPEED_WORD[line_len];
      end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
         t = digit_sum * 10 + int'(ch - CHAR_0);
         digit_sum = (t > 65535) ? 65535 : t;
      end else begin
         digit_err = 1;
      end
      if (line_len < 255) line_len++;
   endfunction

   function automatic panel_type tick_sorter(input logic ec, input logic sc, input logic af,
                                             input logic ab, input logic hb, input logic rb,
                                             input logic rv, input logic [BYTE_W-1:0] rx);
      panel_type p;
      int        slot;
      p.note = MSG_NONE;
      case (mode)
         MODE_RESET_WAIT: begin
            if (!rb) restore_state();
         end
         MODE_CLASSIFY: begin
            if (rb) begin
               mode = MODE_RESET_WAIT;
            end else if (line_waiting) begin
               if (first_char == CHAR_N) begin
                  p.note = MSG_DO_NOTHING;
               end else begin
                  if (fill < QUEUE_DEPTH) begin
                     slot = (head + fill) % QUEUE_DEPTH;
                     reject_log[slot] = (first_char != CHAR_D);
                     fill++;
                  end
                  p.note = MSG_SCANNING;
               end
               clear_line();
               mode = MODE_RUN;
            end
         end
         MODE_SORT_OUT: begin
            if (af) mode = MODE_SORT_BACK;
         end
         MODE_SORT_BACK, MODE_HOME: begin
            if (ab) mode = MODE_RUN;
         end
         default: begin
            mode = MODE_RUN;
            if (rb) begin
               mode = MODE_RESET_WAIT;
            end else if (!ec && !entry_off) begin
               entry_off = 1;
               mode = MODE_CLASSIFY;
            end else if (!sc && fill > 0 && !sort_off) begin
               sort_off = 1;
               if (reject_log[head]) mode = MODE_SORT_OUT;
               head = (head + 1) % QUEUE_DEPTH;
               fill--;
               p.note = MSG_SORTING;
            end else if (hb) begin
               mode = MODE_HOME;
            end else if (line_waiting && word_ok && line_len >= 5) begin
               if (line_len > 5 && !digit_err && digit_sum <= int'(speed_cap)) begin
                  belt_set = digit_sum[DATA_W-1:0];
                  p.note = MSG_SPEED_SET;
               end else begin
                  p.note = MSG_SPEED_BAD;
               end
               clear_line();
            end
            if (ec) entry_off = 0;
            if (sc) sort_off = 0;
         end
      endcase
      if (rv) take_char(rx);

      p.belt     = '0;
      p.drive    = '0;
      p.backward = 0;
      p.led      = 0;
      p.laser    = 1;
      p.pusher   = 0;
      case (mode)
         MODE_CLASSIFY: begin
            p.led    = 1;
            p.laser  = 0;
            p.pusher = 1;
         end
         MODE_SORT_OUT: p.drive = power;
         MODE_SORT_BACK: begin
            p.drive    = power;
            p.backward = 1;
         end
         MODE_HOME: begin
            p.belt     = belt_set;
            p.drive    = power;
            p.backward = 1;
         end
         MODE_RESET_WAIT: ;
         default: p.belt = belt_set;
      endcase
      p.queued = fill[COUNT_W-1:0];
      return p;
   endfunction

   function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin : track
      panel_type want;
      if (reset) begin
         power      = SLIDER_POWER_RST;
         speed_cap  = SPEED_LIMIT_RST;
         boot_speed = DEFAULT_SPEED_RST;
         restore_state();
         panel_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SLIDER_POWER:  power = csr_data;
               CSR_SPEED_LIMIT:   speed_cap = csr_data;
               CSR_DEFAULT_SPEED: boot_speed = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            panel_due.push_back(tick_sorter(req_entry_clear, req_sort_clear,
                                            req_slider_at_front, req_slider_at_back,
                                            req_home_button, req_reset_button,
                                            req_rx_valid, req_rx_byte));
         end
         if (rsp_valid && !rsp_stall) begin
            if (panel_due.size() == 0) begin
               $error("response beat with no prediction pending");
               fails++;
            end else begin
               want = panel_due.pop_front();
               check_field("belt_speed", want.belt, rsp_belt_speed);
               check_field("slider_drive", want.drive, rsp_slider_drive);
               check_field("slider_backward", want.backward, rsp_slider_backward);
               check_field("led_strip_on", want.led, rsp_led_strip_on);
               check_field("laser_on", want.laser, rsp_laser_on);
               check_field("pusher_out", want.pusher, rsp_pusher_out);
               check_field("queued_count", want.queued, rsp_queued_count);
               check_field("message", want.note, rsp_message);
            end
         end
      end
      due_count = panel_due.size();
   end

endmodule

FILE: tb/tb_conveyor_sort_sequencer.sv
// Testbench top for conveyor_sort_sequencer: clock, reset, CSR programming,
// sensor/UART request beats and response stalls; the checker does the scoring.
// Depends on cnvs_pkg, conveyor_sort_sequencer and conveyor_sort_sequencer_checker.
module tb_conveyor_sort_sequencer;
   timeunit 1ns;
   timeprecision 1ps;
   import cnvs_pkg::*;

   localparam int HOLD_CYCLES = 250;
   localparam int STUCK_LIMIT = 3000;

   typedef struct packed {
      logic              entry_clear;
      logic              sort_clear;
      logic              at_front;
      logic              at_back;
      logic              home;
      logic              rst_btn;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_byte;
   } sensor_beat_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_entry_clear;
   logic                 req_sort_clear;
   logic                 req_slider_at_front;
   logic                 req_slider_at_back;
   logic                 req_home_button;
   logic                 req_reset_button;
   logic                 req_rx_valid;
   logic [BYTE_W-1:0]    req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [DATA_W-1:0]    rsp_belt_speed;
   logic [DATA_W-1:0]    rsp_slider_drive;
   logic                 rsp_slider_backward;
   logic                 rsp_led_strip_on;
   logic                 rsp_laser_on;
   logic                 rsp_pusher_out;
   logic [COUNT_W-1:0]   rsp_queued_count;
   logic [MSG_W-1:0]     rsp_message;

   int                   fails;
   int                   due_count;
   int                   beats_sent;
   int                   idle_cycles;
   int                   gap_odds;
   bit                   quiet;
   bit                   hold_request;
   logic [DATA_W-1:0]    speed_cap;

   conveyor_sort_sequencer dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_entry_clear(req_entry_clear), .req_sort_clear(req_sort_clear),
      .req_slider_at_front(req_slider_at_front), .req_slider_at_back(req_slider_at_back),
      .req_home_button(req_home_button), .req_reset_button(req_reset_button),
      .req_rx_valid(req_rx_valid), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_belt_speed(rsp_belt_speed), .rsp_slider_drive(rsp_slider_drive),
      .rsp_slider_backward(rsp_slider_backward), .rsp_led_strip_on(rsp_led_strip_on),
      .rsp_laser_on(rsp_laser_on), .rsp_pusher_out(rsp_pusher_out),
      .rsp_queued_count(rsp_queued_count), .rsp_message(rsp_message)
   );

   conveyor_sort_sequencer_checker audit (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_entry_clear(req_entry_clear), .req_sort_clear(req_sort_clear),
      .req_slider_at_front(req_slider_at_front), .req_slider_at_back(req_slider_at_back),
      .req_home_button(req_home_button), .req_reset_button(req_reset_button),
      .req_rx_valid(req_rx_valid), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_belt_speed(rsp_belt_speed), .rsp_slider_drive(rsp_slider_drive),
      .rsp_slider_backward(rsp_slider_backward), .rsp_led_strip_on(rsp_led_strip_on),
      .rsp_laser_on(rsp_laser_on), .rsp_pusher_out(rsp_pusher_out),
      .rsp_queued_count(rsp_queued_count), .rsp_message(rsp_message),
      .fails(fails), .due_count(due_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic sensor_beat_type idle_belt();
      sensor_beat_type b;
      b.entry_clear = 1'b1;
      b.sort_clear  = 1'b1;
      b.at_front    = 1'b0;
      b.at_back     = 1'b1;
      b.home        = 1'b0;
      b.rst_btn     = 1'b0;
      b.rx_valid    = 1'b0;
      b.rx_byte     = '0;
      return b;
   endfunction

   function automatic sensor_beat_type carrying(input logic [BYTE_W-1:0] ch);
      sensor_beat_type b;
      b = idle_belt();
      b.rx_valid = 1'b1;
      b.rx_byte  = ch;
      return b;
   endfunction

   task automatic load_payload(input sensor_beat_type b);
      req_entry_clear     = b.entry_clear;
      req_sort_clear      = b.sort_clear;
      req_slider_at_front = b.at_front;
      req_slider_at_back  = b.at_back;
      req_home_button     = b.home;
      req_reset_button    = b.rst_btn;
      req_rx_valid        = b.rx_valid;
      req_rx_byte         = b.rx_byte;
   endtask

   // Call at a falling edge; returns at a falling edge with valid still high unless a random gap dropped it.
   task automatic offer(input sensor_beat_type b);
      load_payload(b);
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      @(negedge clock);
      if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   task automatic send_line(input string txt);
      for (int i = 0; i < txt.len(); i++) offer(carrying(txt[i]));
      offer(carrying($urandom_range(0, 1) ? CHAR_CR : CHAR_LF));
      if ($urandom_range(0, 3) == 0) offer(carrying($urandom_range(0, 1) ? CHAR_CR : CHAR_LF));
   endtask

   task automatic program_registers(input logic [DATA_W-1:0] power,
                                    input logic [DATA_W-1:0] cap,
                                    input logic [DATA_W-1:0] boot);
      req_valid = 1'b0;
      wait (due_count == 0);
      repeat (3) @(negedge clock);
      csr_write = 1'b1;
      csr_index = CSR_SLIDER_POWER;
      csr_data  = power;
      @(negedge clock);
      csr_index = CSR_SPEED_LIMIT;
      csr_data  = cap;
      @(negedge clock);
      csr_index = CSR_DEFAULT_SPEED;
      csr_data  = boot;
      @(negedge clock);
      csr_write = 1'b0;
      speed_cap = cap;
   endtask

   task automatic send_label();
      string txt;
      case ($urandom_range(0, 9))
         0, 1, 2: txt = "n";
         3, 4, 5: txt = "d";
         6:       txt = "speed42";
         default: txt = $sformatf("%c", $urandom_range(33, 126));
      endcase
      repeat ($urandom_range(0, 2)) txt = $sformatf("%s%c", txt, $urandom_range(33, 126));
      send_line(txt);
   endtask

   task automatic object_arrives();
      sensor_beat_type b;
      bit              early;
      early = ($urandom_range(0, 3) == 0);
      if (early) send_label();
      b = idle_belt();
      b.entry_clear = 1'b0;
      repeat ($urandom_range(1, 2)) offer(b);
      if (!early) send_label();
      repeat ($urandom_range(1, 3)) offer(idle_belt());
   endtask

   task automatic object_at_slider();
      sensor_beat_type b;
      b = idle_belt();
      b.sort_clear = 1'b0;
      repeat ($urandom_range(1, 2)) offer(b);
      b = idle_belt();
      b.at_front = 1'b1;
      b.at_back  = 1'b0;
      repeat ($urandom_range(1, 2)) offer(b);
      offer(idle_belt());
   endtask

   task automatic speed_command();
      string txt;
      case ($urandom_range(0, 9))
         0, 1, 2: txt = $sformatf("speed%0d", $urandom_range(0, speed_cap));
         3:       txt = $sformatf("speed%0d", speed_cap + 1);
         4:       txt = $sformatf("speed%0d", $urandom_range(0, 65535));
         5:       txt = "speed9999999";
         6:       txt = "speed";
         7:       txt = $sformatf("speed%0dx", $urandom_range(0, 999));
         8:       txt = $sformatf("spe%0d", $urandom_range(0, 99));
         default: txt = $sformatf("speed%05d", $urandom_range(0, 99));
      endcase
      send_line(txt);
   endtask

   task automatic home_run();
      sensor_beat_type b;
      b = idle_belt();
      b.home    = 1'b1;
      b.at_back = 1'b0;
      offer(b);
      repeat ($urandom_range(0, 3)) begin
         b.home = 1'($urandom);
         offer(b);
      end
      offer(idle_belt());
   endtask

   task automatic reset_press();
      sensor_beat_type b;
      b = idle_belt();
      b.rst_btn = 1'b1;
      repeat ($urandom_range(1, 4)) offer(b);
      offer(idle_belt());
   endtask

   task automatic noise_burst();
      sensor_beat_type b;
      repeat ($urandom_range(1, 4)) begin
         b = 15'($urandom);
         offer(b);
      end
   endtask

   task automatic random_scenario();
      int pick;
      pick = $urandom_range(0, 99);
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
      if (pick < 25) object_arrives();
      else if (pick < 45) object_at_slider();
      else if (pick < 60) speed_command();
      else if (pick < 68) home_run();
      else if (pick < 72) reset_press();
      else if (pick < 76) offer(carrying($urandom_range(0, 1) ? CHAR_CR : CHAR_LF));
      else noise_burst();
   endtask

   task automatic directed_checks();
      sensor_beat_type b;
      offer(idle_belt());
      b = carrying(CHAR_D);
      b.entry_clear = 1'b0;
      offer(b);
      offer(carrying(CHAR_CR));
      offer(idle_belt());
      offer(idle_belt());
      b = carrying("q");
      b.entry_clear = 1'b0;
      offer(b);
      offer(carrying(CHAR_LF));
      offer(idle_belt());
      offer(idle_belt());
      b = idle_belt();
      b.sort_clear = 1'b0;
      offer(b);
      offer(idle_belt());
      offer(b);
      b = idle_belt();
      b.at_front = 1'b1;
      b.at_back  = 1'b0;
      offer(b);
      offer(idle_belt());
      b = idle_belt();
      b.home    = 1'b1;
      b.at_back = 1'b0;
      offer(b);
      offer(idle_belt());
      b = idle_belt();
      b.rst_btn = 1'b1;
      offer(b);
      offer(idle_belt());
      send_line("speed9");
      offer(idle_belt());
   endtask

   task automatic fill_queue();
      sensor_beat_type b;
      repeat (QUEUE_DEPTH + 4) begin
         b = carrying($urandom_range(0, 1) ? CHAR_D : 8'($urandom_range(97, 122)));
         b.entry_clear = 1'b0;
         offer(b);
         offer(carrying(CHAR_CR));
         offer(idle_belt());
         offer(idle_belt());
      end
   endtask

   // Receiver side: random stall bursts, or one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            hold_request = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall = 1'b0;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STUCK_LIMIT) begin
         $display("** conveyor_sort_sequencer: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      string txt;
      reset        = 1'b1;
      csr_write    = 1'b0;
      csr_index    = CSR_SLIDER_POWER;
      csr_data     = '0;
      req_valid    = 1'b0;
      load_payload(idle_belt());
      quiet        = 0;
      hold_request = 0;
      gap_odds     = 0;
      beats_sent   = 0;
      speed_cap    = SPEED_LIMIT_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_checks();

      program_registers(16'hFFFF, 16'hFFFF, 16'h0000);
      reset_press();
      gap_odds = 6;
      hold_request = 1;
      fill_queue();
      repeat (QUEUE_DEPTH + 4) object_at_slider();
      txt = "speed";
      repeat (260) txt = {txt, "9"};
      send_line(txt);

      program_registers(16'h0000, 16'h0000, 16'hFFFF);
      reset_press();
      while (beats_sent < 1450) random_scenario();

      program_registers(16'($urandom), 16'($urandom), 16'($urandom));
      reset_press();
      while (beats_sent < 1600) random_scenario();

      program_registers(16'd1234, 16'd30000, 16'd100);
      reset_press();
      quiet = 1;
      while (beats_sent < 1750) random_scenario();

      req_valid = 1'b0;
      wait (due_count == 0);
      repeat (4) @(posedge clock);
      if (fails == 0) begin
         $display("** conveyor_sort_sequencer: PASSED **");
      end else begin
         $display("** conveyor_sort_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
